// ===== design/ppdc_pkg.sv =====
package ppdc_pkg;

    // field widths
    localparam int SAMPLE_W = 10;
    localparam int CMD_W    = 15;
    localparam int TIME_W   = 32;
    localparam int PROD_W   = 2 * CMD_W;
    localparam int QUO_W    = CMD_W + 1;

    // two bits retire per cycle in both serial units
    localparam int MUL_STEPS  = QUO_W / 2;
    localparam int DIV_STEPS  = QUO_W / 2;
    localparam int STEP_CNT_W = $clog2(MUL_STEPS);

    // stream words
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 40;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = CMD_W;

    localparam logic [CFG_IDX_W-1:0] REG_BRAKE_THR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RPM   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OVERLAP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_PEDAL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SEND_PER  = 3'd5;

    localparam logic [SAMPLE_W-1:0] RST_BRAKE_THR = 10'd25;
    localparam logic [CMD_W-1:0]    RST_MAX_RPM   = 15'd5500;
    localparam logic [SAMPLE_W-1:0] RST_OVERLAP   = 10'd52;
    localparam logic [SAMPLE_W-1:0] RST_LOW_PEDAL = 10'd20;
    localparam logic [SAMPLE_W-1:0] RST_DEADBAND  = 10'd30;
    localparam logic [SAMPLE_W-1:0] RST_SEND_PER  = 10'd10;

    localparam logic [CMD_W-1:0] PEDAL_FULL_SCALE   = 15'd1023;
    localparam logic [CMD_W-1:0] COMMAND_FULL_SCALE = 15'd32767;

endpackage

// ===== design/ppdc_mul.sv =====
module ppdc_mul (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [ppdc_pkg::CMD_W-1:0] i_a,
    input  logic [ppdc_pkg::CMD_W-1:0] i_b,
    output logic                       o_done,
    output logic [ppdc_pkg::PROD_W-1:0] o_prod
);
    import ppdc_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_CNT_W-1:0] r_cnt;
    logic [CMD_W-1:0]      r_a;
    logic [QUO_W-1:0]      r_b;
    logic [PROD_W-1:0]     r_acc;

    logic [CMD_W+1:0]      n_part;
    logic [PROD_W-1:0]     n_acc;

    // radix-4 shift-add, multiplier digits taken from the top
    always_comb begin
        case (r_b[QUO_W-1 -: 2])
            2'd0:    n_part = '0;
            2'd1:    n_part = {2'b00, r_a};
            2'd2:    n_part = {1'b0, r_a, 1'b0};
            default: n_part = {2'b00, r_a} + {1'b0, r_a, 1'b0};
        endcase
        n_acc = {r_acc[PROD_W-3:0], 2'b00} + PROD_W'(n_part);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == STEP_CNT_W'(MUL_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= {1'b0, i_b};
            r_acc <= '0;
        end else if (r_busy) begin
            r_b   <= {r_b[QUO_W-3:0], 2'b00};
            r_acc <= n_acc;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ===== design/ppdc_div.sv =====
module ppdc_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ppdc_pkg::PROD_W-1:0] i_dividend,
    input  logic [ppdc_pkg::CMD_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [ppdc_pkg::CMD_W-1:0]  o_quotient
);
    import ppdc_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_CNT_W-1:0] r_cnt;
    logic [CMD_W-1:0]      r_d;
    logic [CMD_W-1:0]      r_rem;
    logic [QUO_W-1:0]      r_num;
    logic [QUO_W-1:0]      r_quo;

    logic [CMD_W:0]        n_t0;
    logic [CMD_W:0]        n_t1;
    logic                  n_ge0;
    logic                  n_ge1;
    logic [CMD_W-1:0]      n_rem0;
    logic [CMD_W-1:0]      n_rem1;

    // two restoring steps per cycle; remainder always stays below the divisor
    always_comb begin
        n_t0   = {r_rem, r_num[QUO_W-1]};
        n_ge0  = n_t0 >= {1'b0, r_d};
        n_rem0 = n_ge0 ? CMD_W'(n_t0 - {1'b0, r_d}) : n_t0[CMD_W-1:0];
        n_t1   = {n_rem0, r_num[QUO_W-2]};
        n_ge1  = n_t1 >= {1'b0, r_d};
        n_rem1 = n_ge1 ? CMD_W'(n_t1 - {1'b0, r_d}) : n_t1[CMD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == STEP_CNT_W'(DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // callers keep the dividend below divisor * 2^16, so the upper part
    // seeds the remainder directly
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_d   <= i_divisor;
            r_rem <= CMD_W'(i_dividend[PROD_W-1:QUO_W]);
            r_num <= i_dividend[QUO_W-1:0];
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem1;
            r_num <= {r_num[QUO_W-3:0], 2'b00};
            r_quo <= {r_quo[QUO_W-3:0], n_ge0, n_ge1};
        end
    end

    assign o_done     = r_done;
    // top quotient bit is zero only when the dividend is below divisor * 2^15
    assign o_quotient = r_quo[CMD_W-1:0];

endmodule

// ===== design/pedal_plausibility_drive_command.sv =====
// channel   dir   handshake                      word fields (lowest bit up)
// s_axis    in    s_axis_tvalid / s_axis_tready  brake_sample, pedal_sample,
//                                                start_pressed, now_ms
// m_axis    out   m_axis_tvalid / m_axis_tready  drive_armed, overlap_latched,
//                                                send_strobe, command_word,
//                                                display_rpm
// cfg       in    i_cfg_we (no wait)             i_cfg_index, i_cfg_data
//
// A zero command (disarmed, latched, zero max_rpm) goes from S_IDLE through S_DONE to
// m_axis_tvalid. Otherwise five serial passes (8 radix-4 steps each, plus start and
// handoff: pedal * max_rpm, / 1023, rpm * 32767 / max_rpm, * max_rpm, / 32767) run
// before S_DONE raises it. s_axis_tready stays low until the word moves into the output
// register, which waits while the last word is held.
// Reset (synchronous, active low): disarmed, unlatched, send time zero, default registers.
module pedal_plausibility_drive_command (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // brake_sample[9:0], pedal_sample[19:10], start_pressed[20], now_ms[52:21]
    input  logic [ppdc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // drive_armed[0], overlap_latched[1], send_strobe[2], command_word[17:3],
    // display_rpm[32:18]
    output logic [ppdc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                             i_cfg_we,
    input  logic [ppdc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ppdc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import ppdc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL1, S_DIV1, S_DIV2, S_MUL2, S_DIV3, S_DONE
    } t_state;

    t_state r_state;

    logic [SAMPLE_W-1:0] r_brake_thr;
    logic [CMD_W-1:0]    r_max_rpm;
    logic [SAMPLE_W-1:0] r_overlap;
    logic [SAMPLE_W-1:0] r_low_pedal;
    logic [SAMPLE_W-1:0] r_deadband;
    logic [SAMPLE_W-1:0] r_send_per;

    logic                r_armed;
    logic                r_latch;
    logic [TIME_W-1:0]   r_last_send;
    logic                r_strobe;
    logic [CMD_W-1:0]    r_cmd;
    logic [CMD_W-1:0]    r_disp;

    logic                r_mul_start;
    logic [CMD_W-1:0]    r_mul_b;
    logic                r_div_start;
    logic [PROD_W-1:0]   r_div_dividend;
    logic [CMD_W-1:0]    r_div_divisor;

    logic                r_m_valid;
    logic [OUT_TDATA_W-1:0] r_m_data;

    logic                mul_done;
    logic [PROD_W-1:0]   mul_prod;
    logic                div_done;
    logic [CMD_W-1:0]    div_quo;

    logic [SAMPLE_W-1:0] in_brake;
    logic [SAMPLE_W-1:0] in_pedal;
    logic                in_start;
    logic [TIME_W-1:0]   in_now;

    logic                s_accept;
    logic                pressed;
    logic                released;
    logic                toggle;
    logic                n_armed;
    logic                n_latch;
    logic                n_calc;
    logic [TIME_W-1:0]   elapsed;
    logic                n_strobe;
    logic [CMD_W-1:0]    rpm_db;
    logic                out_free;

    assign in_brake = s_axis_tdata[SAMPLE_W-1:0];
    assign in_pedal = s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
    assign in_start = s_axis_tdata[2*SAMPLE_W];
    assign in_now   = s_axis_tdata[2*SAMPLE_W+TIME_W:2*SAMPLE_W+1];

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;

    // arm / latch decision and send strobe for the sample at the port; deadband on the quotient
    always_comb begin
        pressed  = in_brake > r_brake_thr;
        released = in_pedal <= r_low_pedal;
        toggle   = pressed && in_start && released;
        if (!r_armed) begin
            n_armed = toggle;
            n_latch = 1'b0;
        end else if (toggle) begin
            n_armed = 1'b0;
            n_latch = 1'b0;
        end else begin
            n_armed = 1'b1;
            n_latch = r_latch;
        end
        if (n_armed) begin
            if (!n_latch && pressed && (in_pedal >= r_overlap)) begin
                n_latch = 1'b1;
            end
            if (n_latch && released) begin
                n_latch = 1'b0;
            end
        end
        n_calc   = n_armed && !n_latch && (r_max_rpm != '0);
        elapsed  = in_now - r_last_send;
        n_strobe = elapsed >= TIME_W'(r_send_per);
        rpm_db   = (div_quo < CMD_W'(r_deadband)) ? '0 : div_quo;
    end

    ppdc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_start),
        .i_a     (r_max_rpm),
        .i_b     (r_mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    ppdc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_div_dividend),
        .i_divisor  (r_div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brake_thr <= RST_BRAKE_THR;
            r_max_rpm   <= RST_MAX_RPM;
            r_overlap   <= RST_OVERLAP;
            r_low_pedal <= RST_LOW_PEDAL;
            r_deadband  <= RST_DEADBAND;
            r_send_per  <= RST_SEND_PER;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_BRAKE_THR: r_brake_thr <= i_cfg_data[SAMPLE_W-1:0];
                REG_MAX_RPM:   r_max_rpm   <= i_cfg_data;
                REG_OVERLAP:   r_overlap   <= i_cfg_data[SAMPLE_W-1:0];
                REG_LOW_PEDAL: r_low_pedal <= i_cfg_data[SAMPLE_W-1:0];
                REG_DEADBAND:  r_deadband  <= i_cfg_data[SAMPLE_W-1:0];
                REG_SEND_PER:  r_send_per  <= i_cfg_data[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_armed     <= 1'b0;
            r_latch     <= 1'b0;
            r_last_send <= '0;
            r_mul_start <= 1'b0;
            r_div_start <= 1'b0;
            r_m_valid   <= 1'b0;
        end else begin
            r_mul_start <= 1'b0;
            r_div_start <= 1'b0;
            // S_DONE refills the output word on its own
            if (r_m_valid && m_axis_tready && (r_state != S_DONE)) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        r_armed  <= n_armed;
                        r_latch  <= n_latch;
                        r_strobe <= n_strobe;
                        if (n_strobe) begin
                            r_last_send <= in_now;
                        end
                        if (n_calc) begin
                            r_mul_b     <= CMD_W'(in_pedal);
                            r_mul_start <= 1'b1;
                            r_state     <= S_MUL1;
                        end else begin
                            r_cmd   <= '0;
                            r_disp  <= '0;
                            r_state <= S_DONE;
                        end
                    end
                end
                S_MUL1: begin
                    if (mul_done) begin
                        r_div_dividend <= mul_prod;
                        r_div_divisor  <= PEDAL_FULL_SCALE;
                        r_div_start    <= 1'b1;
                        r_state        <= S_DIV1;
                    end
                end
                S_DIV1: begin
                    // rpm * 32767 as a shift and subtract
                    if (div_done) begin
                        r_div_dividend <= {rpm_db, {CMD_W{1'b0}}} - PROD_W'(rpm_db);
                        r_div_divisor  <= r_max_rpm;
                        r_div_start    <= 1'b1;
                        r_state        <= S_DIV2;
                    end
                end
                S_DIV2: begin
                    if (div_done) begin
                        r_cmd       <= div_quo;
                        r_mul_b     <= div_quo;
                        r_mul_start <= 1'b1;
                        r_state     <= S_MUL2;
                    end
                end
                S_MUL2: begin
                    if (mul_done) begin
                        r_div_dividend <= mul_prod;
                        r_div_divisor  <= COMMAND_FULL_SCALE;
                        r_div_start    <= 1'b1;
                        r_state        <= S_DIV3;
                    end
                end
                S_DIV3: begin
                    if (div_done) begin
                        r_disp  <= div_quo;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (out_free) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= OUT_TDATA_W'({r_disp, r_cmd, r_strobe,
                                                   r_latch, r_armed});
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    a_latch_needs_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[0] || !m_axis_tdata[1]))
        else $error("overlap latch reported while disarmed");

    a_cmd_needs_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[2*CMD_W+2:3] != '0))
            |-> (m_axis_tdata[0] && !m_axis_tdata[1]))
        else $error("nonzero command while latched or disarmed");

    a_mul_done_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == S_MUL1 || r_state == S_MUL2))
        else $error("multiplier finished outside a multiply pass");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV1 || r_state == S_DIV2 || r_state == S_DIV3))
        else $error("divider finished outside a divide pass");

endmodule
